// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Property checked at every rising edge, reset cycles included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/core/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, configuration indexes and reset values, hold lengths and result bit positions.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_STOP     = 3'd1;
  localparam logic [2:0] CMD_WRITE    = 3'd2;
  localparam logic [2:0] CMD_READ     = 3'd3;
  localparam logic [2:0] CMD_WAIT_ACK = 3'd4;

  localparam logic CFG_TICKS_PER_US   = 1'b0;
  localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

  localparam logic [7:0] TICKS_PER_US_RST   = 8'd1;
  localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;

  localparam logic [2:0] HOLD_4U = 3'd4;
  localparam logic [2:0] HOLD_2U = 3'd2;
  localparam logic [2:0] HOLD_1U = 3'd1;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Result word layout.
  localparam int OUT_SCL_BIT   = 0;
  localparam int OUT_SDA_BIT   = 1;
  localparam int OUT_DRV_BIT   = 2;
  localparam int OUT_BUSY_BIT  = 3;
  localparam int OUT_DONE_BIT  = 4;
  localparam int OUT_RX_LSB    = 5;
  localparam int OUT_ACK_BIT   = 13;

endpackage

// File: rtl/core/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick driven pin sequencer for start, stop, byte write, byte read and ack wait.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_      slave      tdata: tx_byte, send_ack, sda_in; tuser: cmd_valid, mode
//  out_     master     tdata: scl, sda, drive, busy, done, rx_byte, ack_ok
//  cfg_     write      index 0 ticks_per_us, index 1 ack_poll_limit
//
//  One tick transfer is taken per cycle while the output is not stalled; its result appears in the cycle after.
//  The sequencer step, the hold counters and the pins advance once per transfer.
//  The result register frees in the cycle it is taken, so a stalled output
//  only holds the input side while the result waits.
//  Reset puts the pins at bus idle (SCL, SDA high, driven) and the engine idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9]
  input  logic [3:0]  in_tuser,   // cmd_valid[0], mode[3:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl, sda, sda_drive, busy, done, rx_byte[7:0], ack_ok
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_S0, ST_S1, ST_S2, ST_P0, ST_P1, ST_P2, ST_W0, ST_W1, ST_W2,
    ST_WD, ST_R0, ST_R1, ST_A0, ST_A1, ST_A2, ST_K0, ST_K1, ST_K2, ST_K3
  } step_t;

  typedef struct packed {
    step_t       step;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift;
    logic [2:0]  hold;
    logic [7:0]  presc;
    logic [7:0]  poll;
    logic        ack_choice;
    logic        scl;
    logic        sda;
    logic        sda_oe;
    logic        ack_flag;
    logic [7:0]  rx_hold;
  } seq_t;

  function automatic seq_t enter_fn(input seq_t s, input step_t st);
    seq_t r;
    r       = s;
    r.step  = st;
    r.presc = '0;
    r.hold  = '0;
    unique case (st)
      ST_S0: begin r.sda_oe = 1'b1; r.sda = 1'b1; r.scl = 1'b1; r.hold = i2cmbe_pkg::HOLD_4U; end
      ST_S1: begin r.sda = 1'b0; r.hold = i2cmbe_pkg::HOLD_4U; end
      ST_S2: r.scl = 1'b0;
      ST_P0: begin r.sda_oe = 1'b1; r.scl = 1'b0; r.sda = 1'b0; r.hold = i2cmbe_pkg::HOLD_4U; end
      ST_P1: begin r.scl = 1'b1; r.sda = 1'b1; r.hold = i2cmbe_pkg::HOLD_4U; end
      ST_W0: begin
        r.sda_oe = 1'b1; r.scl = 1'b0; r.sda = s.shift[7]; r.hold = i2cmbe_pkg::HOLD_2U;
      end
      ST_W1: begin r.scl = 1'b1; r.hold = i2cmbe_pkg::HOLD_2U; end
      ST_W2: begin r.scl = 1'b0; r.hold = i2cmbe_pkg::HOLD_2U; end
      ST_R0: begin r.sda_oe = 1'b0; r.scl = 1'b0; r.hold = i2cmbe_pkg::HOLD_2U; end
      ST_R1: begin r.scl = 1'b1; r.hold = i2cmbe_pkg::HOLD_1U; end
      ST_A0: begin
        r.scl = 1'b0; r.sda_oe = 1'b1; r.sda = ~s.ack_choice; r.hold = i2cmbe_pkg::HOLD_2U;
      end
      ST_A1: begin r.scl = 1'b1; r.hold = i2cmbe_pkg::HOLD_2U; end
      ST_A2: begin r.scl = 1'b0; r.rx_hold = s.shift; end
      ST_K0: begin r.sda_oe = 1'b0; r.sda = 1'b1; r.hold = i2cmbe_pkg::HOLD_1U; end
      ST_K1: begin r.scl = 1'b1; r.hold = i2cmbe_pkg::HOLD_1U; end
      ST_K2: r.poll = '0;
      ST_K3: begin r.scl = 1'b0; r.ack_flag = 1'b1; end
      default: ;
    endcase
    return r;
  endfunction

  function automatic seq_t next_fn(input seq_t s);
    seq_t r;
    r = s;
    unique case (s.step)
      ST_S0: r = enter_fn(s, ST_S1);
      ST_S1: r = enter_fn(s, ST_S2);
      ST_P0: r = enter_fn(s, ST_P1);
      ST_P1: r = enter_fn(s, ST_P2);
      ST_W0: r = enter_fn(s, ST_W1);
      ST_W1: r = enter_fn(s, ST_W2);
      ST_W2: begin
        r.bit_cnt = s.bit_cnt + 4'd1;
        r.shift   = {s.shift[6:0], 1'b0};
        r = enter_fn(r, (r.bit_cnt >= i2cmbe_pkg::BITS_PER_BYTE) ? ST_WD : ST_W0);
      end
      ST_R0: r = enter_fn(s, ST_R1);
      ST_R1: begin
        r.bit_cnt = s.bit_cnt + 4'd1;
        r = enter_fn(r, (r.bit_cnt >= i2cmbe_pkg::BITS_PER_BYTE) ? ST_A0 : ST_R0);
      end
      ST_A0: r = enter_fn(s, ST_A1);
      ST_A1: r = enter_fn(s, ST_A2);
      ST_K0: r = enter_fn(s, ST_K1);
      ST_K1: r = enter_fn(s, ST_K2);
      default: r.step = ST_IDLE;
    endcase
    return r;
  endfunction

  seq_t        seq_r, seq_nxt, seq_cur;
  logic [7:0]  tpu_r, tpu_nxt;
  logic [7:0]  limit_r, limit_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  logic        cmd_valid, send_ack, sda_in;
  logic [2:0]  mode;
  logic [7:0]  tx_byte;
  logic        in_xfer;
  logic        busy, done;
  logic [7:0]  rate;
  logic [8:0]  presc_inc;
  step_t       first_step;

  assign cmd_valid = in_tuser[0];
  assign mode      = in_tuser[3:1];
  assign tx_byte   = in_tdata[7:0];
  assign send_ack  = in_tdata[8];
  assign sda_in    = in_tdata[9];

  assign in_tready = ~out_valid_r | out_tready;
  assign in_xfer   = in_tvalid & in_tready;
  assign rate      = (tpu_r == 8'd0) ? 8'd1 : tpu_r;

  always_comb begin
    case (mode)
      i2cmbe_pkg::CMD_START: first_step = ST_S0;
      i2cmbe_pkg::CMD_STOP:  first_step = ST_P0;
      i2cmbe_pkg::CMD_WRITE: first_step = ST_W0;
      i2cmbe_pkg::CMD_READ:  first_step = ST_R0;
      default:               first_step = ST_K0;
    endcase
  end

  always_comb begin
    seq_cur = seq_r;
    if (seq_r.step == ST_IDLE && cmd_valid && mode <= i2cmbe_pkg::CMD_WAIT_ACK) begin
      seq_cur.bit_cnt    = '0;
      seq_cur.poll       = '0;
      seq_cur.ack_choice = send_ack;
      seq_cur.shift      = (mode == i2cmbe_pkg::CMD_WRITE) ? tx_byte : 8'd0;
      seq_cur = enter_fn(seq_cur, first_step);
    end

    busy = (seq_cur.step != ST_IDLE);
    case (seq_cur.step) inside
      ST_S2, ST_P2, ST_WD, ST_A2, ST_K3: done = 1'b1;
      default:                           done = 1'b0;
    endcase

    presc_inc = {1'b0, seq_cur.presc} + 9'd1;
    seq_nxt   = seq_cur;
    if (done) begin
      seq_nxt.step = ST_IDLE;
    end else if (seq_cur.step == ST_K2) begin
      if (!sda_in) begin
        seq_nxt = enter_fn(seq_cur, ST_K3);
      end else if (seq_cur.poll >= limit_r) begin
        seq_nxt.ack_flag = 1'b0;
        seq_nxt = enter_fn(seq_nxt, ST_P0);
      end else begin
        seq_nxt.poll = seq_cur.poll + 8'd1;
      end
    end else if (seq_cur.step != ST_IDLE) begin
      if (seq_cur.step == ST_R1 && seq_cur.presc == 8'd0 && seq_cur.hold == 3'd1) begin
        seq_nxt.shift = {seq_cur.shift[6:0], sda_in};
      end
      if (seq_cur.hold == 3'd0) begin
        seq_nxt = next_fn(seq_nxt);
      end else if (presc_inc >= {1'b0, rate}) begin
        seq_nxt.presc = '0;
        seq_nxt.hold  = seq_cur.hold - 3'd1;
        if (seq_nxt.hold == 3'd0) begin
          seq_nxt = next_fn(seq_nxt);
        end
      end else begin
        seq_nxt.presc = presc_inc[7:0];
      end
    end

    out_data_nxt = {2'b00, seq_cur.ack_flag, seq_cur.rx_hold, done, busy,
                    seq_cur.sda_oe, seq_cur.sda, seq_cur.scl};
  end

  always_comb begin
    tpu_nxt   = tpu_r;
    limit_nxt = limit_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        i2cmbe_pkg::CFG_TICKS_PER_US:   tpu_nxt   = cfg_wdata;
        i2cmbe_pkg::CFG_ACK_POLL_LIMIT: limit_nxt = cfg_wdata;
        default: ;
      endcase
    end
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.step       <= ST_IDLE;
      seq_r.bit_cnt    <= '0;
      seq_r.shift      <= '0;
      seq_r.hold       <= '0;
      seq_r.presc      <= '0;
      seq_r.poll       <= '0;
      seq_r.ack_choice <= 1'b0;
      seq_r.scl        <= 1'b1;
      seq_r.sda        <= 1'b1;
      seq_r.sda_oe     <= 1'b1;
      seq_r.ack_flag   <= 1'b0;
      seq_r.rx_hold    <= '0;
      tpu_r            <= i2cmbe_pkg::TICKS_PER_US_RST;
      limit_r          <= i2cmbe_pkg::ACK_POLL_LIMIT_RST;
      out_valid_r      <= 1'b0;
    end else begin
      tpu_r       <= tpu_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        seq_r <= seq_nxt;
      end
    end
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/core/i2cmbe_chk.sv
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port level assertions on the result channel and input ready, bound to the bit engine module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cmbe_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic res_done;
  logic res_busy;

  assign res_done = out_tdata[i2cmbe_pkg::OUT_DONE_BIT];
  assign res_busy = out_tdata[i2cmbe_pkg::OUT_BUSY_BIT];

  `ASSERT_CLK(a_done_is_busy, clk, rst_n, out_tvalid && res_done |-> res_busy)
  `ASSERT_CLK(a_stall_holds, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  `ASSERT_CLK(a_stall_keeps_valid, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `ASSERT_CLK(a_ready_follows_sink, clk, rst_n, out_tready |-> in_tready)
  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_tvalid)

endmodule

bind i2c_master_bit_engine i2cmbe_chk u_i2cmbe_chk (.*);
